@@ hw/rtl/mesh_vertex_normals_defines.svh @@
// Assertion macros for the mesh vertex normal block.
// Needs nothing else; the top level pulls this in for its checks.
`ifndef MESH_VERTEX_NORMALS_DEFINES_SVH
`define MESH_VERTEX_NORMALS_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define MVN_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mesh_vertex_normals: same-cycle check failed");

// Next-cycle implication, reset masks the check.
`define MVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mesh_vertex_normals: next-cycle check failed");

`endif

@@ hw/rtl/mvn_pkg.sv @@
// Shared widths, constants and op codes of the mesh vertex normal block.
// No dependencies; used by the normalizer and the top level.
package mvn_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COUNT_W          = 7;
   localparam int COUNT_RESET      = 64;
   localparam int IDX_W            = 6;
   localparam int OP_W             = 2;
   localparam int POS_W            = 16;
   localparam int NRM_W            = 16;
   localparam int SUM_W            = 24;
   localparam int VEC_W            = 36;
   localparam int ONE_Q14          = 16384;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD     = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_FINISH   = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

endpackage

@@ hw/rtl/mesh_vertex_normals.sv @@
// Per-vertex normals of a triangle mesh by face-normal averaging.
// Request channel (req_*): op 0 loads a vertex position, op 1 adds a triangle,
// op 2 emits every vertex normal in use, then clears the sums. Op 3 is dropped.
// Response channel (rsp_*): one response per vertex on op 2, ascending index,
// rsp_last on the final one. Ops 0, 1 and 3 give no response.
// CSR channel (csr_*): vertex count, always ready; write it only while idle.
// One request is worked at a time. Op 0, op 3 and a triangle with a corner out
// of range need no work after acceptance. Op 1 accepts, reads the three corner
// positions, forms the cross product on one 17x17 multiplier, starts the
// normalizer (shift steps, squares, a 31-bit root, three 15-bit divides) and
// then does three sum read-modify-writes on the sum RAM; a zero-area triangle
// skips the squares, root and divides. Op 2 accepts, then runs each vertex sum
// in turn through the same normalizer, a zero sum likewise skipping them.
// A finished response sits in an output register; a stalled receiver holds
// the block at the next response, and requests are taken again once the last
// response is loaded. Reset clears the sums (valid bits) and sets the vertex
// count to 64; positions read as undefined until loaded.
module mesh_vertex_normals #(
   parameter int MAX_VERTICES = mvn_pkg::MAX_VERTICES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mvn_pkg::OP_W-1:0]           req_op,
   input  logic [mvn_pkg::IDX_W-1:0]          req_vertex_slot,
   input  logic signed [mvn_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [mvn_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [mvn_pkg::POS_W-1:0]   req_pos_z,
   input  logic [mvn_pkg::IDX_W-1:0]          req_corner_a,
   input  logic [mvn_pkg::IDX_W-1:0]          req_corner_b,
   input  logic [mvn_pkg::IDX_W-1:0]          req_corner_c,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mvn_pkg::IDX_W-1:0]          rsp_out_vertex,
   output logic signed [mvn_pkg::NRM_W-1:0]   rsp_normal_x,
   output logic signed [mvn_pkg::NRM_W-1:0]   rsp_normal_y,
   output logic signed [mvn_pkg::NRM_W-1:0]   rsp_normal_z,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mvn_pkg::COUNT_W-1:0]        csr_vertex_count
);

   import mvn_pkg::*;

   `include "mesh_vertex_normals_defines.svh"

   localparam int AW     = $clog2(MAX_VERTICES);
   localparam int PW     = 3 * POS_W;
   localparam int SW     = 3 * SUM_W;
   localparam int EDGE_W = POS_W + 1;
   localparam int PROD_W = 2 * EDGE_W;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_FETCH    = 11'b00000000010,
      ST_CROSS    = 11'b00000000100,
      ST_FSTART   = 11'b00000001000,
      ST_FNORM    = 11'b00000010000,
      ST_ACC_RD   = 11'b00000100000,
      ST_ACC_WR   = 11'b00001000000,
      ST_EM_RD    = 11'b00010000000,
      ST_EM_START = 11'b00100000000,
      ST_EM_NORM  = 11'b01000000000,
      ST_EMIT     = 11'b10000000000
   } state_type;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                       input logic signed [NRM_W-1:0] d);
      logic signed [SUM_W:0] t;
      t = (SUM_W+1)'(s) + (SUM_W+1)'(d);
      if (t[SUM_W] != t[SUM_W-1]) begin
         return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return t[SUM_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [AW-1:0]            ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic [PW-1:0]            pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   logic [1:0]               step_ff, step_in;
   logic [2:0]               mcnt_ff, mcnt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [VEC_W-1:0]  crx_ff, crx_in, cry_ff, cry_in, crz_ff, crz_in;
   logic [COUNT_W-1:0]       v_ff, v_in;
   logic [MAX_VERTICES-1:0]  sum_vld_ff, sum_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_vertex_ff, rsp_vertex_in;
   logic signed [NRM_W-1:0]  rsp_nx_ff, rsp_nx_in, rsp_ny_ff, rsp_ny_in, rsp_nz_ff, rsp_nz_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]       cnt_eff;
   logic                     slot_ok, corners_ok, is_last;
   logic [AW-1:0]            corner_sel, sum_addr;
   logic                     pos_we, sum_we;
   logic [PW-1:0]            pos_rd;
   logic [SW-1:0]            sum_rd, sum_cur, sum_wdata;
   logic signed [SUM_W-1:0]  sx, sy, sz;
   logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z, opa, opb;
   logic signed [VEC_W-1:0]  prod_ext, nv_x, nv_y, nv_z;
   logic                     norm_start, norm_done;
   logic signed [NRM_W-1:0]  n_x, n_y, n_z;

   always_comb begin
      if (count_ff == '0) begin
         cnt_eff = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_VERTICES)) begin
         cnt_eff = COUNT_W'(MAX_VERTICES);
      end else begin
         cnt_eff = count_ff;
      end
   end

   assign slot_ok    = COUNT_W'(req_vertex_slot) < COUNT_W'(MAX_VERTICES);
   assign corners_ok = (COUNT_W'(req_corner_a) < cnt_eff) && (COUNT_W'(req_corner_b) < cnt_eff)
                       && (COUNT_W'(req_corner_c) < cnt_eff);
   assign is_last    = (v_ff + COUNT_W'(1)) == cnt_eff;

   always_comb begin
      case (step_ff)
         2'd0:    corner_sel = ca_ff;
         2'd1:    corner_sel = cb_ff;
         default: corner_sel = cc_ff;
      endcase
   end

   assign sum_addr = ((state_ff == ST_ACC_RD) || (state_ff == ST_ACC_WR)) ? corner_sel
                                                                           : v_ff[AW-1:0];
   // an entry never written since reset or finish reads as zero
   assign sum_cur  = sum_vld_ff[sum_addr] ? sum_rd : '0;
   assign sx       = sum_cur[SW-1 -: SUM_W];
   assign sy       = sum_cur[SW-SUM_W-1 -: SUM_W];
   assign sz       = sum_cur[SUM_W-1:0];
   assign sum_wdata = {sat_add(sx, n_x), sat_add(sy, n_y), sat_add(sz, n_z)};

   assign e1x = EDGE_W'($signed(pb_ff[PW-1 -: POS_W])) - EDGE_W'($signed(pa_ff[PW-1 -: POS_W]));
   assign e1y = EDGE_W'($signed(pb_ff[PW-POS_W-1 -: POS_W]))
                - EDGE_W'($signed(pa_ff[PW-POS_W-1 -: POS_W]));
   assign e1z = EDGE_W'($signed(pb_ff[POS_W-1:0])) - EDGE_W'($signed(pa_ff[POS_W-1:0]));
   assign e2x = EDGE_W'($signed(pc_ff[PW-1 -: POS_W])) - EDGE_W'($signed(pa_ff[PW-1 -: POS_W]));
   assign e2y = EDGE_W'($signed(pc_ff[PW-POS_W-1 -: POS_W]))
                - EDGE_W'($signed(pa_ff[PW-POS_W-1 -: POS_W]));
   assign e2z = EDGE_W'($signed(pc_ff[POS_W-1:0])) - EDGE_W'($signed(pa_ff[POS_W-1:0]));

   // six products, alternating add and subtract into the three components
   always_comb begin
      case (mcnt_ff)
         3'd0:    begin opa = e1y; opb = e2z; end
         3'd1:    begin opa = e1z; opb = e2y; end
         3'd2:    begin opa = e1z; opb = e2x; end
         3'd3:    begin opa = e1x; opb = e2z; end
         3'd4:    begin opa = e1x; opb = e2y; end
         default: begin opa = e1y; opb = e2x; end
      endcase
   end

   assign prod_ext   = VEC_W'(prod_ff);
   assign norm_start = (state_ff == ST_FSTART) || (state_ff == ST_EM_START);
   assign nv_x       = (state_ff == ST_FSTART) ? crx_ff : VEC_W'(sx);
   assign nv_y       = (state_ff == ST_FSTART) ? cry_ff : VEC_W'(sy);
   assign nv_z       = (state_ff == ST_FSTART) ? crz_ff : VEC_W'(sz);

   assign req_ready  = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign pos_we     = req_valid && req_ready && (req_op == OP_LOAD) && slot_ok;
   assign sum_we     = (state_ff == ST_ACC_WR);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ca_in         = ca_ff;
      cb_in         = cb_ff;
      cc_in         = cc_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      pc_in         = pc_ff;
      step_in       = step_ff;
      mcnt_in       = mcnt_ff;
      prod_in       = prod_ff;
      crx_in        = crx_ff;
      cry_in        = cry_ff;
      crz_in        = crz_ff;
      v_in          = v_ff;
      sum_vld_in    = sum_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_nx_in     = rsp_nx_ff;
      rsp_ny_in     = rsp_ny_ff;
      rsp_nz_in     = rsp_nz_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         count_in = csr_vertex_count;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_TRIANGLE: begin
                     ca_in = req_corner_a[AW-1:0];
                     cb_in = req_corner_b[AW-1:0];
                     cc_in = req_corner_c[AW-1:0];
                     if (corners_ok) begin
                        step_in  = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  OP_FINISH: begin
                     v_in     = '0;
                     state_in = ST_EM_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            // read data arrives in the cycle after its corner address
            case (step_ff)
               2'd1:    pa_in = pos_rd;
               2'd2:    pb_in = pos_rd;
               2'd3:    pc_in = pos_rd;
               default: ;
            endcase
            if (step_ff == 2'd3) begin
               mcnt_in  = '0;
               state_in = ST_CROSS;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_CROSS: begin
            if (mcnt_ff != 3'd6) begin
               prod_in = opa * opb;
            end
            case (mcnt_ff)
               3'd1:    crx_in = prod_ext;
               3'd2:    crx_in = crx_ff - prod_ext;
               3'd3:    cry_in = prod_ext;
               3'd4:    cry_in = cry_ff - prod_ext;
               3'd5:    crz_in = prod_ext;
               3'd6:    crz_in = crz_ff - prod_ext;
               default: ;
            endcase
            if (mcnt_ff == 3'd6) begin
               state_in = ST_FSTART;
            end else begin
               mcnt_in = mcnt_ff + 3'd1;
            end
         end
         ST_FSTART: state_in = ST_FNORM;
         ST_FNORM: begin
            if (norm_done) begin
               step_in  = '0;
               state_in = ST_ACC_RD;
            end
         end
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            // next corner reads only after this write lands
            sum_vld_in[sum_addr] = 1'b1;
            if (step_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_ACC_RD;
            end
         end
         ST_EM_RD:    state_in = ST_EM_START;
         ST_EM_START: state_in = ST_EM_NORM;
         ST_EM_NORM: begin
            if (norm_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = v_ff[IDX_W-1:0];
               rsp_nx_in     = n_x;
               rsp_ny_in     = n_y;
               rsp_nz_in     = n_z;
               rsp_last_in   = is_last;
               if (is_last) begin
                  sum_vld_in = '0;
                  state_in   = ST_IDLE;
               end else begin
                  v_in     = v_ff + COUNT_W'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(COUNT_RESET);
         sum_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_vld_ff   <= sum_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ca_ff         <= ca_in;
      cb_ff         <= cb_in;
      cc_ff         <= cc_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      pc_ff         <= pc_in;
      step_ff       <= step_in;
      mcnt_ff       <= mcnt_in;
      prod_ff       <= prod_in;
      crx_ff        <= crx_in;
      cry_ff        <= cry_in;
      crz_ff        <= crz_in;
      v_ff          <= v_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_nx_ff     <= rsp_nx_in;
      rsp_ny_ff     <= rsp_ny_in;
      rsp_nz_ff     <= rsp_nz_in;
      rsp_last_ff   <= rsp_last_in;
   end

   mvn_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_VERTICES)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (req_vertex_slot[AW-1:0]),
      .wr_data ({req_pos_x, req_pos_y, req_pos_z}),
      .rd_addr (corner_sel),
      .rd_data (pos_rd)
   );

   mvn_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_VERTICES)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_addr),
      .wr_data (sum_wdata),
      .rd_addr (sum_addr),
      .rd_data (sum_rd)
   );

   mvn_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .vec_x  (nv_x),
      .vec_y  (nv_y),
      .vec_z  (nv_z),
      .done   (norm_done),
      .norm_x (n_x),
      .norm_y (n_y),
      .norm_z (n_z)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_vertex = rsp_vertex_ff;
   assign rsp_normal_x   = rsp_nx_ff;
   assign rsp_normal_y   = rsp_ny_ff;
   assign rsp_normal_z   = rsp_nz_ff;
   assign rsp_last       = rsp_last_ff;

   `MVN_ASSERT_NOW(a_norm_done_awaited, clock, reset, norm_done,
                   (state_ff == ST_FNORM) || (state_ff == ST_EM_NORM))
   `MVN_ASSERT_NEXT(a_emit_waits_on_stall, clock, reset,
                    (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_ready, state_ff == ST_EMIT)
   `MVN_ASSERT_NOW(a_req_only_when_free, clock, reset, req_ready,
                   !norm_start && !sum_we)

endmodule

@@ hw/rtl/mvn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds vertex positions and normal sums.
module mvn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_data = rd_q_ff;

endmodule

@@ hw/rtl/mvn_norm.sv @@
// Vector normalizer: scales a signed 3-vector to a Q1.14 unit vector.
// Bit-serial shift, sequential squares, digit-serial root and divide; uses mvn_pkg.
module mvn_norm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [mvn_pkg::VEC_W-1:0] vec_x,
   input  logic signed [mvn_pkg::VEC_W-1:0] vec_y,
   input  logic signed [mvn_pkg::VEC_W-1:0] vec_z,
   output logic                              done,
   output logic signed [mvn_pkg::NRM_W-1:0] norm_x,
   output logic signed [mvn_pkg::NRM_W-1:0] norm_y,
   output logic signed [mvn_pkg::NRM_W-1:0] norm_z
);

   import mvn_pkg::*;

   localparam int MAG_W  = VEC_W;
   localparam int HI     = 30;          // largest magnitude lands in [2^29, 2^30)
   localparam int PROD_W = 2 * HI;
   localparam int SQ_W   = PROD_W + 2;
   localparam int ROOT_W = SQ_W / 2;
   localparam int REM_W  = ROOT_W + 3;
   localparam int QBITS  = 15;
   localparam int NUM_W  = HI + QBITS;
   localparam int DIV_W  = ROOT_W + 1;

   typedef enum logic [4:0] {
      N_IDLE  = 5'b00001,
      N_SHIFT = 5'b00010,
      N_SQ    = 5'b00100,
      N_ROOT  = 5'b01000,
      N_DIV   = 5'b10000
   } norm_state_type;

   norm_state_type nst_ff, nst_in;
   logic                done_ff, done_in;
   logic [2:0]          neg_ff, neg_in;
   logic [MAG_W-1:0]    mag_x_ff, mag_x_in, mag_y_ff, mag_y_in, mag_z_ff, mag_z_in;
   logic [MAG_W-1:0]    m_ff, m_in;
   logic [1:0]          idx_ff, idx_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [REM_W-1:0]    rrem_ff, rrem_in;
   logic [4:0]          rcnt_ff, rcnt_in;
   logic [DIV_W-1:0]    drem_ff, drem_in;
   logic [QBITS-1:0]    low_ff, low_in;
   logic [QBITS-1:0]    q_ff, q_in;
   logic [3:0]          dcnt_ff, dcnt_in;
   logic                dload_ff, dload_in;
   logic signed [NRM_W-1:0] nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;

   logic [MAG_W-1:0]    abs_x, abs_y, abs_z, max_xy, mag_sel;
   logic [REM_W-1:0]    r_shift, trial;
   logic [NUM_W-1:0]    num;
   logic [DIV_W-1:0]    r2;
   logic                ge;
   logic [QBITS-1:0]    qf, qc;
   logic signed [NRM_W-1:0] sval;

   always_comb begin
      abs_x  = vec_x[VEC_W-1] ? MAG_W'(-vec_x) : MAG_W'(vec_x);
      abs_y  = vec_y[VEC_W-1] ? MAG_W'(-vec_y) : MAG_W'(vec_y);
      abs_z  = vec_z[VEC_W-1] ? MAG_W'(-vec_z) : MAG_W'(vec_z);
      max_xy = (abs_x > abs_y) ? abs_x : abs_y;

      case (idx_ff)
         2'd0:    mag_sel = mag_x_ff;
         2'd1:    mag_sel = mag_y_ff;
         default: mag_sel = mag_z_ff;
      endcase

      r_shift = {rrem_ff[REM_W-3:0], sq_ff[SQ_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});

      // component * 16384 plus half the length, rounded quotient below
      num  = NUM_W'({mag_sel[HI-1:0], {(QBITS-1){1'b0}}}) + NUM_W'(root_ff >> 1);
      r2   = {drem_ff[DIV_W-2:0], low_ff[QBITS-1]};
      ge   = (r2 >= DIV_W'(root_ff));
      qf   = {q_ff[QBITS-2:0], ge};
      qc   = (qf > QBITS'(ONE_Q14)) ? QBITS'(ONE_Q14) : qf;
      sval = neg_ff[idx_ff] ? -NRM_W'(qc) : NRM_W'(qc);

      nst_in   = nst_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      mag_x_in = mag_x_ff;
      mag_y_in = mag_y_ff;
      mag_z_in = mag_z_ff;
      m_in     = m_ff;
      idx_in   = idx_ff;
      prod_in  = prod_ff;
      sq_in    = sq_ff;
      root_in  = root_ff;
      rrem_in  = rrem_ff;
      rcnt_in  = rcnt_ff;
      drem_in  = drem_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      dcnt_in  = dcnt_ff;
      dload_in = dload_ff;
      nx_in    = nx_ff;
      ny_in    = ny_ff;
      nz_in    = nz_ff;

      case (nst_ff)
         N_IDLE: begin
            if (start) begin
               neg_in   = {vec_z[VEC_W-1], vec_y[VEC_W-1], vec_x[VEC_W-1]};
               mag_x_in = abs_x;
               mag_y_in = abs_y;
               mag_z_in = abs_z;
               m_in     = (max_xy > abs_z) ? max_xy : abs_z;
               nst_in   = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (m_ff == '0) begin
               nx_in   = '0;
               ny_in   = '0;
               nz_in   = '0;
               done_in = 1'b1;
               nst_in  = N_IDLE;
            end else if (|m_ff[MAG_W-1:HI]) begin
               // right shifts truncate each magnitude
               mag_x_in = mag_x_ff >> 1;
               mag_y_in = mag_y_ff >> 1;
               mag_z_in = mag_z_ff >> 1;
               m_in     = m_ff >> 1;
            end else if (!m_ff[HI-1]) begin
               mag_x_in = mag_x_ff << 1;
               mag_y_in = mag_y_ff << 1;
               mag_z_in = mag_z_ff << 1;
               m_in     = m_ff << 1;
            end else begin
               idx_in = '0;
               sq_in  = '0;
               nst_in = N_SQ;
            end
         end
         N_SQ: begin
            if (idx_ff != 2'd3) begin
               prod_in = mag_sel[HI-1:0] * mag_sel[HI-1:0];
            end
            if (idx_ff != 2'd0) begin
               sq_in = sq_ff + SQ_W'(prod_ff);
            end
            if (idx_ff == 2'd3) begin
               root_in = '0;
               rrem_in = '0;
               rcnt_in = 5'(ROOT_W - 1);
               nst_in  = N_ROOT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         N_ROOT: begin
            // one result bit per cycle, consume two radicand bits
            if (r_shift >= trial) begin
               rrem_in = r_shift - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rrem_in = r_shift;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            sq_in = sq_ff << 2;
            if (rcnt_ff == '0) begin
               idx_in   = '0;
               dload_in = 1'b1;
               nst_in   = N_DIV;
            end else begin
               rcnt_in = rcnt_ff - 5'd1;
            end
         end
         N_DIV: begin
            if (dload_ff) begin
               drem_in  = DIV_W'(num[NUM_W-1:QBITS]);
               low_in   = num[QBITS-1:0];
               q_in     = '0;
               dcnt_in  = 4'(QBITS - 1);
               dload_in = 1'b0;
            end else begin
               drem_in = ge ? (r2 - DIV_W'(root_ff)) : r2;
               low_in  = low_ff << 1;
               q_in    = qf;
               if (dcnt_ff == '0) begin
                  case (idx_ff)
                     2'd0:    nx_in = sval;
                     2'd1:    ny_in = sval;
                     default: nz_in = sval;
                  endcase
                  if (idx_ff == 2'd2) begin
                     done_in = 1'b1;
                     nst_in  = N_IDLE;
                  end else begin
                     idx_in   = idx_ff + 2'd1;
                     dload_in = 1'b1;
                  end
               end else begin
                  dcnt_in = dcnt_ff - 4'd1;
               end
            end
         end
         default: nst_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nst_ff  <= N_IDLE;
         done_ff <= 1'b0;
      end else begin
         nst_ff  <= nst_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      m_ff     <= m_in;
      idx_ff   <= idx_in;
      prod_ff  <= prod_in;
      sq_ff    <= sq_in;
      root_ff  <= root_in;
      rrem_ff  <= rrem_in;
      rcnt_ff  <= rcnt_in;
      drem_ff  <= drem_in;
      low_ff   <= low_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      dload_ff <= dload_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      nz_ff    <= nz_in;
   end

   assign done   = done_ff;
   assign norm_x = nx_ff;
   assign norm_y = ny_ff;
   assign norm_z = nz_ff;

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for mesh_vertex_normals: face-normal averaging per vertex.
// Needs mvn_pkg and the block itself. It holds its own bit-exact predictor.
`timescale 1ns / 1ps

module testbench;
   import mvn_pkg::*;

   localparam int NV          = 64;
   localparam int SETTLE      = 200;
   localparam int CYCLE_LIMIT = 900000;
   localparam longint SUM_HI  = 8388607;
   localparam longint SUM_LO  = -8388608;

   typedef struct {
      op_type             op;
      logic [IDX_W-1:0]   slot;
      logic signed [15:0] x, y, z;
      logic [IDX_W-1:0]   a, b, c;
   } mesh_request;

   typedef struct {
      logic [IDX_W-1:0]   vertex;
      logic signed [15:0] nx, ny, nz;
      logic               last;
   } vertex_normal;

   typedef struct {
      longint x, y, z;
   } wide_vec;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [OP_W-1:0] req_op;
   logic [IDX_W-1:0] req_vertex_slot, req_corner_a, req_corner_b, req_corner_c;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic rsp_valid, rsp_ready;
   logic [IDX_W-1:0] rsp_out_vertex;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_last;
   logic csr_valid, csr_ready;
   logic [COUNT_W-1:0] csr_vertex_count;

   // predictor state
   int pos_tab [NV][3];
   longint sum_tab [NV][3];
   int unsigned count_reg;
   vertex_normal normals_due[$];

   int mismatches;
   bit calm;
   int stall_left;
   int unsigned cycles;

   mesh_vertex_normals u_top (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vertex_normal want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (normals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: vertex %0d n=(%0d,%0d,%0d) last %0b",
                        rsp_out_vertex, rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_last);
         end else begin
            want = normals_due.pop_front();
            if (rsp_out_vertex !== want.vertex || rsp_normal_x !== want.nx ||
                rsp_normal_y !== want.ny || rsp_normal_z !== want.nz ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want v%0d (%0d,%0d,%0d) l%0b got v%0d (%0d,%0d,%0d) l%0b",
                           want.vertex, want.nx, want.ny, want.nz, want.last,
                           rsp_out_vertex, rsp_normal_x, rsp_normal_y, rsp_normal_z,
                           rsp_last);
            end
         end
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // scale a vector to a Q1.14 unit direction; zero length gives zero
   function automatic void unit_q14(input wide_vec v, output logic signed [15:0] n [3]);
      longint c [3];
      longint unsigned mag [3];
      bit neg [3];
      longint unsigned m, sq, len, q;
      int rsh, lsh;
      c = '{v.x, v.y, v.z};
      m = 0; sq = 0; rsh = 0; lsh = 0;
      for (int k = 0; k < 3; k++) begin
         n[k] = '0;
         neg[k] = c[k] < 0;
         mag[k] = neg[k] ? longint'(-c[k]) : longint'(c[k]);
         if (mag[k] > m) m = mag[k];
      end
      if (m == 0) return;
      while (m >= (64'd1 << 30)) begin m >>= 1; rsh++; end
      while (m < (64'd1 << 29)) begin m <<= 1; lsh++; end
      for (int k = 0; k < 3; k++) begin
         mag[k] = (mag[k] >> rsh) << lsh;
         sq += mag[k] * mag[k];
      end
      len = int_sqrt(sq);
      if (len == 0) return;
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * ONE_Q14 + len / 2) / len;
         if (q > ONE_Q14) q = ONE_Q14;
         n[k] = neg[k] ? -16'(q) : 16'(q);
      end
   endfunction

   function automatic int unsigned vertices_in_use();
      if (count_reg == 0) return 1;
      if (count_reg > NV) return NV;
      return count_reg;
   endfunction

   // advance the predictor by one accepted request
   function automatic void predict_normals(mesh_request r);
      int unsigned cnt;
      int idx [3];
      longint e1 [3], e2 [3];
      wide_vec cr;
      logic signed [15:0] n [3];
      vertex_normal out;
      cnt = vertices_in_use();
      case (r.op)
         OP_LOAD: begin
            pos_tab[r.slot] = '{int'(r.x), int'(r.y), int'(r.z)};
         end
         OP_TRIANGLE: begin
            if (r.a < cnt && r.b < cnt && r.c < cnt) begin
               idx = '{r.a, r.b, r.c};
               for (int k = 0; k < 3; k++) begin
                  e1[k] = longint'(pos_tab[r.b][k]) - pos_tab[r.a][k];
                  e2[k] = longint'(pos_tab[r.c][k]) - pos_tab[r.a][k];
               end
               cr.x = e1[1] * e2[2] - e1[2] * e2[1];
               cr.y = e1[2] * e2[0] - e1[0] * e2[2];
               cr.z = e1[0] * e2[1] - e1[1] * e2[0];
               unit_q14(cr, n);
               foreach (idx[i])
                  for (int k = 0; k < 3; k++) begin
                     sum_tab[idx[i]][k] += n[k];
                     if (sum_tab[idx[i]][k] > SUM_HI) sum_tab[idx[i]][k] = SUM_HI;
                     if (sum_tab[idx[i]][k] < SUM_LO) sum_tab[idx[i]][k] = SUM_LO;
                  end
            end
         end
         OP_FINISH: begin
            for (int v = 0; v < cnt; v++) begin
               cr.x = sum_tab[v][0];
               cr.y = sum_tab[v][1];
               cr.z = sum_tab[v][2];
               unit_q14(cr, n);
               out.vertex = IDX_W'(v);
               out.nx = n[0];
               out.ny = n[1];
               out.nz = n[2];
               out.last = (v + 1 == cnt);
               normals_due.push_back(out);
            end
            foreach (sum_tab[v]) sum_tab[v] = '{0, 0, 0};
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(mesh_request r);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_vertex_slot <= r.slot;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      req_pos_z <= r.z;
      req_corner_a <= r.a;
      req_corner_b <= r.b;
      req_corner_c <= r.c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_normals(r);
   endtask

   task automatic load_vertex(int slot, int x, int y, int z);
      mesh_request r;
      r = '{OP_LOAD, slot, x, y, z, $urandom, $urandom, $urandom};
      send_request(r);
   endtask

   task automatic add_triangle(int a, int b, int c);
      mesh_request r;
      r = '{OP_TRIANGLE, $urandom, $urandom, $urandom, $urandom, a, b, c};
      send_request(r);
   endtask

   task automatic send_op(op_type op);
      mesh_request r;
      r = '{op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      send_request(r);
   endtask

   // hold requests until every normal is out and the block has gone quiet
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (normals_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_count(int unsigned value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_vertex_count <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      count_reg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_vertex_loads();
      for (int s = 0; s < NV; s++)
         load_vertex(s, $urandom, $urandom, $urandom);
      load_vertex(0, -32768, -32768, -32768);
      load_vertex(1, 32767, 32767, -32768);
      load_vertex(2, 32767, -32768, 32767);
      load_vertex(3, 0, 0, 0);
      load_vertex(4, 1, 2, 3);
      load_vertex(5, 2, 4, 6);
   endtask

   task automatic test_directed_triangles();
      add_triangle(0, 1, 2);
      add_triangle(2, 1, 0);
      add_triangle(3, 3, 3);   // repeated corner, zero area
      add_triangle(3, 4, 5);   // collinear corners, zero area
      add_triangle(63, 62, 61);
      send_op(OP_NOP);
      send_op(OP_FINISH);
   endtask

   task automatic test_count_limits();
      write_count(0);          // behaves as one vertex
      add_triangle(0, 1, 0);   // dropped
      add_triangle(0, 0, 0);
      send_op(OP_FINISH);
      write_count(127);        // clamps to the full store
      add_triangle(10, 20, 30);
      send_op(OP_FINISH);
      write_count(4);
      add_triangle(0, 1, 4);   // dropped, corner out of range
      add_triangle(0, 1, 2);
      add_triangle(1, 2, 3);
      send_op(OP_FINISH);
   endtask

   task automatic random_mesh_phase(int unsigned cnt, int items);
      int pick;
      write_count(cnt);
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            add_triangle($urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1),
                         $urandom_range(0, cnt - 1));
         else if (pick < 85)
            load_vertex($urandom_range(0, NV - 1), $urandom, $urandom, $urandom);
         else if (pick < 92)
            add_triangle($urandom_range(0, NV - 1), $urandom_range(0, NV - 1),
                         $urandom_range(0, NV - 1));
         else
            send_op(OP_NOP);
         if (i == items / 2 && $urandom_range(0, 1) == 0)
            send_op(OP_FINISH);
      end
      send_op(OP_FINISH);
   endtask

   task automatic test_random_meshes();
      for (int p = 0; p < 6; p++) begin
         calm = (p == 3);
         random_mesh_phase($urandom_range(3, 12), 14);
         if (p == 1) wait_drained();
      end
      random_mesh_phase(64, 10);
      calm = 1'b1;
      random_mesh_phase(1, 8);
      random_mesh_phase($urandom_range(2, 8), 20);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= '0;
      req_vertex_slot <= '0;
      req_pos_x <= '0;
      req_pos_y <= '0;
      req_pos_z <= '0;
      req_corner_a <= '0;
      req_corner_b <= '0;
      req_corner_c <= '0;
      csr_valid <= 1'b0;
      csr_vertex_count <= '0;
      rsp_ready <= 1'b0;
      stall_left = 0;
      cycles = 0;
      mismatches = 0;
      calm = 1'b0;
      count_reg = COUNT_RESET;
      foreach (sum_tab[v]) sum_tab[v] = '{0, 0, 0};
      foreach (pos_tab[v]) pos_tab[v] = '{0, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_vertex_loads();
      test_directed_triangles();
      test_count_limits();
      test_random_meshes();

      wait_drained();
      if (mismatches == 0 && normals_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ mesh_vertex_normals.f @@
+incdir+hw/rtl
hw/rtl/mvn_pkg.sv
hw/rtl/mvn_ram.sv
hw/rtl/mvn_norm.sv
hw/rtl/mesh_vertex_normals.sv
test/testbench.sv
